// ----- rtl/core/vmmeg_pkg.sv -----
// types and constants shared by the vm memory expansion gas block
package vmmeg_pkg;

  localparam int unsigned MAX_OFS_BITS = 24;
  localparam int unsigned TGT_BITS     = MAX_OFS_BITS + 1;
  localparam int unsigned WORD_BYTES   = 32;
  localparam int unsigned ROW_BYTES    = 64;
  localparam int unsigned LANE_BYTES   = 8;
  localparam int unsigned LANE_BITS    = 64;
  localparam int unsigned NUM_BANKS    = 8;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_STORE  = 3'd1;
  localparam logic [2:0] CMD_BSTORE = 3'd2;
  localparam logic [2:0] CMD_SIZE   = 3'd3;
  localparam logic [2:0] CMD_EXPAND = 3'd4;

  typedef enum logic [2:0] {
    K_PASS,
    K_FAIL,
    K_LOAD,
    K_WSTORE,
    K_BSTORE,
    K_SIZE,
    K_EXPAND
  } kind_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] offset;
    logic        offset_high_nonzero;
    logic [31:0] length;
    logic        length_high_nonzero;
    logic [63:0] value_w0;
    logic [63:0] value_w1;
    logic [63:0] value_w2;
    logic [63:0] value_w3;
    logic [62:0] gas_in;
  } in_t;

  typedef struct packed {
    logic               status;
    logic signed [63:0] gas_out;
    logic [63:0]        data_w0;
    logic [63:0]        data_w1;
    logic [63:0]        data_w2;
    logic [63:0]        data_w3;
  } out_t;

  typedef struct packed {
    kind_e                   kind;
    logic [TGT_BITS-1:0]     target;
    logic [MAX_OFS_BITS-1:0] ofs;
    logic [255:0]            value;
    logic [62:0]             gas;
  } entry_t;

endpackage

// ----- rtl/core/vmmeg_ram.sv -----
// generic single-port ram with byte enables and registered read
module vmmeg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [WIDTH/8-1:0] be_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [WIDTH-1:0]   wdata_i,
  input  logic               re_i,
  output logic [WIDTH-1:0]   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH / 8; i++) begin
        if (be_i[i]) begin
          mem_q[addr_i][8*i +: 8] <= wdata_i[8*i +: 8];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/vmmeg_fifo.sv -----
// two-entry queue between the classify front and the execute back
module vmmeg_fifo import vmmeg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t     slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/core/vmmeg_front.sv -----
// front: accepts transactions, checks bounds and classifies each command
module vmmeg_front import vmmeg_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 14
) (
  input  logic   in_valid_i,
  input  in_t    in_i,
  output logic   in_stall_o,
  input  logic   q_full_i,
  input  logic   clearing_i,
  output logic   push_o,
  output entry_t entry_o
);

  localparam int unsigned AB = OFFSET_BITS + 1;

  logic          ofs_bad;
  logic          len_zero;
  logic          len_bad;
  logic [AB-1:0] ofs_ext;
  logic [AB-1:0] len_ext;

  assign ofs_bad  = in_i.offset_high_nonzero || ((in_i.offset >> OFFSET_BITS) != 32'd0);
  assign len_zero = !in_i.length_high_nonzero && (in_i.length == 32'd0);
  assign len_bad  = in_i.length_high_nonzero || ((in_i.length >> OFFSET_BITS) != 32'd0);
  assign ofs_ext  = {1'b0, in_i.offset[OFFSET_BITS-1:0]};
  assign len_ext  = {1'b0, in_i.length[OFFSET_BITS-1:0]};

  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    entry_o.kind   = K_PASS;
    entry_o.target = '0;
    entry_o.ofs    = MAX_OFS_BITS'(in_i.offset[OFFSET_BITS-1:0]);
    entry_o.value  = {in_i.value_w3, in_i.value_w2, in_i.value_w1, in_i.value_w0};
    entry_o.gas    = in_i.gas_in;
    unique case (in_i.cmd) inside
      CMD_LOAD, CMD_STORE: begin
        if (ofs_bad) begin
          entry_o.kind = K_FAIL;
        end else begin
          entry_o.kind   = (in_i.cmd == CMD_LOAD) ? K_LOAD : K_WSTORE;
          entry_o.target = TGT_BITS'(ofs_ext + AB'(WORD_BYTES));
        end
      end
      CMD_BSTORE: begin
        if (ofs_bad) begin
          entry_o.kind = K_FAIL;
        end else begin
          entry_o.kind   = K_BSTORE;
          entry_o.value  = {in_i.value_w0[7:0], 248'd0};
          entry_o.target = TGT_BITS'(ofs_ext + AB'(1));
        end
      end
      CMD_SIZE: begin
        entry_o.kind = K_SIZE;
      end
      CMD_EXPAND: begin
        if (!len_zero) begin
          if (ofs_bad || len_bad) begin
            entry_o.kind = K_FAIL;
          end else begin
            entry_o.kind   = K_EXPAND;
            entry_o.target = TGT_BITS'(ofs_ext + len_ext);
          end
        end
      end
      default: begin
        entry_o.kind = K_PASS;
      end
    endcase
  end

endmodule

// ----- rtl/core/vmmeg_back.sv -----
// back: expansion gas, banked memory access and the result register
module vmmeg_back import vmmeg_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 14
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   head_valid_i,
  input  entry_t head_i,
  output logic   pop_o,
  output logic   clearing_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output out_t   out_o
);

  localparam int unsigned AB         = OFFSET_BITS + 1;
  localparam int unsigned RAW        = (OFFSET_BITS > 5) ? OFFSET_BITS - 5 : 1;
  localparam int unsigned BANK_DEPTH = 1 << (OFFSET_BITS - 5);
  localparam longint unsigned WMAX   = 64'd1 << (OFFSET_BITS - 4);
  localparam int unsigned WW         = $clog2(WMAX + 1);
  localparam longint unsigned CMAX   = WMAX * WMAX / 512 + 3 * WMAX;
  localparam int unsigned CW         = $clog2(CMAX + 1);
  localparam int unsigned SW         = WW + 5;

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  logic           st_q, st_d;
  logic [RAW-1:0] clr_cnt_q, clr_cnt_d;
  logic [WW-1:0]  size_q, size_d;
  logic [CW-1:0]  paid_q, paid_d;

  // classify stage (fifo head)
  logic [AB-1:0]        a_ofs;
  logic [AB-1:0]        a_tgt;
  logic [5:0]           a_rot;
  logic [AB:0]          a_round;
  logic [WW-1:0]        a_w;
  logic                 a_need;
  logic [2*WW-1:0]      a_sq;
  logic [7:0]           a_win [ROW_BYTES];
  logic                 a_mask [ROW_BYTES];
  logic [LANE_BITS-1:0] a_wlane [NUM_BANKS];
  logic [7:0]           a_wbe [NUM_BANKS];
  logic [RAW-1:0]       a_row [NUM_BANKS];

  // execute stage
  logic                 b_valid_q, b_valid_d;
  kind_e                b_kind_q;
  logic [62:0]          b_gas_q;
  logic [WW-1:0]        b_w_q;
  logic                 b_need_q;
  logic [2*WW-1:0]      b_sq_q;
  logic [5:0]           b_rot_q;
  logic [LANE_BITS-1:0] b_wlane_q [NUM_BANKS];
  logic [7:0]           b_wbe_q [NUM_BANKS];
  logic [RAW-1:0]       b_row_q [NUM_BANKS];
  logic                 b_fire;
  logic [CW-1:0]        b_cost;
  logic [CW-1:0]        b_delta;
  logic [63:0]          b_gas_ext;
  logic [63:0]          b_gas_new;
  logic                 b_grow_kind;
  logic                 b_do_grow;
  logic                 b_neg;
  logic                 b_status;
  logic [63:0]          b_gas_out;
  logic                 b_re;
  logic                 b_we;

  // read-out stage
  logic          c_valid_q, c_valid_d;
  kind_e         c_kind_q;
  logic          c_status_q;
  logic [63:0]   c_gas_q;
  logic [SW-1:0] c_size_q;
  logic [5:0]    c_rot_q;
  logic          c_fire;
  logic [7:0]    c_rwin [ROW_BYTES];
  logic [255:0]  c_ld;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // memory bank ports
  logic                 ram_we;
  logic [7:0]           ram_be [NUM_BANKS];
  logic [RAW-1:0]       ram_addr [NUM_BANKS];
  logic [LANE_BITS-1:0] ram_wdata [NUM_BANKS];
  logic [LANE_BITS-1:0] ram_rdata [NUM_BANKS];

  assign clearing_o = (st_q == ST_CLEAR);
  assign pop_o      = (st_q == ST_RUN) && head_valid_i && !b_valid_q;
  assign c_fire     = c_valid_q && (!out_valid_q || !out_stall_i);
  assign b_fire     = b_valid_q && (!c_valid_q || c_fire);

  always_comb begin : a_stage
    logic [5:0]    d;
    logic [5:0]    lane_dist;
    logic [AB-1:0] lane_base;
    logic [AB-1:0] bank_addr;
    a_ofs     = AB'(head_i.ofs[OFFSET_BITS-1:0]);
    a_tgt     = head_i.target[AB-1:0];
    a_rot     = a_ofs[5:0];
    a_round   = {1'b0, a_tgt} + (AB + 1)'(WORD_BYTES - 1);
    a_w       = a_round[AB:5];
    a_need    = {size_q, 5'b00000} < SW'(a_tgt);
    a_sq      = a_w * a_w;
    lane_base = {a_ofs[AB-1:3], 3'b000};
    for (int p = 0; p < ROW_BYTES; p++) begin
      d = 6'(p) - a_rot;
      a_win[p]  = d[5] ? 8'h00 : head_i.value[255 - 8 * d[4:0] -: 8];
      a_mask[p] = (head_i.kind == K_WSTORE) ? !d[5] : (d == 6'd0);
    end
    for (int b = 0; b < NUM_BANKS; b++) begin
      lane_dist = 6'(LANE_BYTES * b) - {a_rot[5:3], 3'b000};
      bank_addr = lane_base + AB'(lane_dist);
      a_row[b]  = RAW'(bank_addr >> 6);
      for (int j = 0; j < LANE_BYTES; j++) begin
        a_wlane[b][LANE_BITS - 1 - 8 * j -: 8] = a_win[LANE_BYTES * b + j];
        a_wbe[b][LANE_BYTES - 1 - j]           = a_mask[LANE_BYTES * b + j];
      end
    end
  end

  always_comb begin
    b_cost      = CW'(b_sq_q >> 9) + CW'({b_w_q, 1'b0}) + CW'(b_w_q);
    b_delta     = b_cost - paid_q;
    b_gas_ext   = {1'b0, b_gas_q};
    b_gas_new   = b_gas_ext - 64'(b_delta);
    b_grow_kind = b_kind_q inside {K_LOAD, K_WSTORE, K_BSTORE, K_EXPAND};
    b_do_grow   = b_valid_q && b_grow_kind && b_need_q;
    b_neg       = b_do_grow && b_gas_new[63];
    b_status    = (b_kind_q == K_FAIL) || b_neg;
    b_gas_out   = b_do_grow ? b_gas_new : b_gas_ext;
    b_re        = b_fire && (b_kind_q == K_LOAD) && !b_neg;
    b_we        = b_fire && ((b_kind_q == K_WSTORE) || (b_kind_q == K_BSTORE)) && !b_neg;
  end

  always_comb begin
    st_d      = st_q;
    clr_cnt_d = clr_cnt_q;
    unique case (st_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + RAW'(1);
        if (clr_cnt_q == RAW'(BANK_DEPTH - 1)) begin
          st_d = ST_RUN;
        end
      end
      ST_RUN: begin
        st_d = ST_RUN;
      end
      default: begin
        st_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    size_d = size_q;
    paid_d = paid_q;
    if (b_fire && b_do_grow) begin
      size_d = b_w_q;
      paid_d = b_cost;
    end
    b_valid_d   = pop_o ? 1'b1 : (b_fire ? 1'b0 : b_valid_q);
    c_valid_d   = b_fire ? 1'b1 : (c_fire ? 1'b0 : c_valid_q);
    out_valid_d = c_fire || (out_valid_q && out_stall_i);
  end

  always_comb begin
    ram_we = clearing_o ? 1'b1 : b_we;
    for (int b = 0; b < NUM_BANKS; b++) begin
      ram_be[b]    = clearing_o ? 8'hff : b_wbe_q[b];
      ram_addr[b]  = clearing_o ? clr_cnt_q : b_row_q[b];
      ram_wdata[b] = clearing_o ? '0 : b_wlane_q[b];
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    vmmeg_ram #(
      .WIDTH (LANE_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .be_i    (ram_be[g]),
      .addr_i  (ram_addr[g]),
      .wdata_i (ram_wdata[g]),
      .re_i    (b_re),
      .rdata_o (ram_rdata[g])
    );
  end

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int j = 0; j < LANE_BYTES; j++) begin
        c_rwin[LANE_BYTES * b + j] = ram_rdata[b][LANE_BITS - 1 - 8 * j -: 8];
      end
    end
    for (int k = 0; k < WORD_BYTES; k++) begin
      c_ld[255 - 8 * k -: 8] = c_rwin[6'(c_rot_q + 6'(k))];
    end
    out_d.status  = c_status_q;
    out_d.gas_out = c_gas_q;
    out_d.data_w0 = '0;
    out_d.data_w1 = '0;
    out_d.data_w2 = '0;
    out_d.data_w3 = '0;
    if ((c_kind_q == K_LOAD) && !c_status_q) begin
      out_d.data_w0 = c_ld[63:0];
      out_d.data_w1 = c_ld[127:64];
      out_d.data_w2 = c_ld[191:128];
      out_d.data_w3 = c_ld[255:192];
    end else if (c_kind_q == K_SIZE) begin
      out_d.data_w0 = 64'(c_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_cnt_q   <= '0;
      size_q      <= '0;
      paid_q      <= '0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_cnt_q   <= clr_cnt_d;
      size_q      <= size_d;
      paid_q      <= paid_d;
      b_valid_q   <= b_valid_d;
      c_valid_q   <= c_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_kind_q  <= head_i.kind;
      b_gas_q   <= head_i.gas;
      b_w_q     <= a_w;
      b_need_q  <= a_need;
      b_sq_q    <= a_sq;
      b_rot_q   <= a_rot;
      b_wlane_q <= a_wlane;
      b_wbe_q   <= a_wbe;
      b_row_q   <= a_row;
    end
    if (b_fire) begin
      c_kind_q   <= b_kind_q;
      c_status_q <= b_status;
      c_gas_q    <= b_gas_out;
      c_size_q   <= {size_q, 5'b00000};
      c_rot_q    <= b_rot_q;
    end
    if (c_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/core/vm_memory_with_expansion_gas.sv -----
// top level of the vm memory with expansion gas block
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_i  (in_t)
// out      output     out_valid_o / out_stall_i out_o (out_t)
//
// the back pops a new transaction only while its execute stage is empty, so
// each growth check reads the size and paid cost that the item before set
// an accepted transaction passes the queue, the execute and read-out registers and the result register
// after reset a clearing pass zeroes all 2^(OFFSET_BITS-5) rows of each bank
// (512 by default) with in_stall_o high
// a two-entry queue keeps accepting while the result register waits on out_stall_i
module vm_memory_with_expansion_gas import vmmeg_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic   q_full;
  logic   push;
  entry_t entry;
  logic   head_valid;
  entry_t head;
  logic   pop;
  logic   clearing;

  vmmeg_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .entry_o    (entry)
  );

  vmmeg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  vmmeg_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

endmodule

// ----- dv/tb_vm_memory_with_expansion_gas.sv -----
// testbench for the vm memory block: directed and random transactions checked against a local memory and gas predictor
module tb_vm_memory_with_expansion_gas;
  import vmmeg_pkg::*;

  localparam int unsigned      OFS_BITS     = 14;
  localparam longint unsigned  MAX_OFS      = (64'd1 << OFS_BITS) - 64'd1;
  localparam int unsigned      MEM_BYTES    = 1 << (OFS_BITS + 1);
  localparam int               CLK_PERIOD   = 10;
  localparam int               RANDOM_ITEMS = 500;
  localparam int               DRAIN_CYCLES = 20;
  localparam int               LIMIT_TIME   = 5_000_000;
  localparam logic [2:0]       CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]       CMD_SPARE_HI = 3'd7;
  localparam logic             STATUS_OOG   = 1'b1;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  // predictor state
  logic [7:0]      mem_image [MEM_BYTES] = '{default: 8'h00};
  longint unsigned grown_words  = 0;
  longint unsigned charged_cost = 0;
  out_t            expected_results [$];

  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int oog_count       = 0;
  int quiet_left      = 0;
  int stall_left      = 0;
  int free_left       = 0;

  vm_memory_with_expansion_gas #(
    .OFFSET_BITS(OFS_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint unsigned total_cost(input longint unsigned words);
    return words * words / 512 + 3 * words;
  endfunction

  function automatic longint unsigned growth_charge(input longint unsigned bytes);
    if (grown_words * 32 >= bytes) return 0;
    return total_cost((bytes + 31) / 32) - charged_cost;
  endfunction

  function automatic void apply_growth(input longint unsigned bytes,
                                       inout logic signed [63:0] gas);
    if (grown_words * 32 < bytes) begin
      gas          = gas - growth_charge(bytes);
      grown_words  = (bytes + 31) / 32;
      charged_cost = total_cost(grown_words);
    end
  endfunction

  function automatic out_t compute_access(input in_t t);
    out_t               r;
    logic signed [63:0] gas;
    logic [63:0]        byte_ofs;
    logic [63:0]        len;
    logic               ofs_bad;
    logic [255:0]       word;
    r        = '0;
    gas      = {1'b0, t.gas_in};
    byte_ofs = 64'(t.offset);
    len      = 64'(t.length);
    ofs_bad  = t.offset_high_nonzero || byte_ofs > MAX_OFS;
    word     = '0;
    case (t.cmd) inside
      CMD_LOAD, CMD_STORE, CMD_BSTORE: begin
        if (ofs_bad) begin
          r.status = STATUS_OOG;
        end else begin
          apply_growth(byte_ofs + ((t.cmd == CMD_BSTORE) ? 1 : 32), gas);
          if (gas < 0) begin
            r.status = STATUS_OOG;
          end else if (t.cmd == CMD_LOAD) begin
            for (int i = 0; i < 32; i++) word[255 - 8 * i -: 8] = mem_image[byte_ofs + i];
            r.data_w0 = word[63:0];
            r.data_w1 = word[127:64];
            r.data_w2 = word[191:128];
            r.data_w3 = word[255:192];
          end else if (t.cmd == CMD_STORE) begin
            word = {t.value_w3, t.value_w2, t.value_w1, t.value_w0};
            for (int i = 0; i < 32; i++) mem_image[byte_ofs + i] = word[255 - 8 * i -: 8];
          end else begin
            mem_image[byte_ofs] = t.value_w0[7:0];
          end
        end
      end
      CMD_SIZE: begin
        r.data_w0 = grown_words * 32;
      end
      CMD_EXPAND: begin
        if (t.length_high_nonzero || len != 0) begin
          if (ofs_bad || t.length_high_nonzero || len > MAX_OFS) begin
            r.status = STATUS_OOG;
          end else begin
            apply_growth(byte_ofs + len, gas);
            if (gas < 0) r.status = STATUS_OOG;
          end
        end
      end
      default: begin
      end
    endcase
    r.gas_out = gas;
    if (r.status == STATUS_OOG) oog_count++;
    return r;
  endfunction

  function automatic in_t random_item();
    in_t t;
    t.cmd                 = 3'($urandom_range(CMD_LOAD, CMD_SPARE_HI));
    t.offset              = $urandom;
    t.offset_high_nonzero = 1'($urandom);
    t.length              = $urandom;
    t.length_high_nonzero = 1'($urandom);
    t.value_w0            = {$urandom, $urandom};
    t.value_w1            = {$urandom, $urandom};
    t.value_w2            = {$urandom, $urandom};
    t.value_w3            = {$urandom, $urandom};
    t.gas_in              = 63'({$urandom, $urandom});
    return t;
  endfunction

  function automatic in_t make_item(input logic [2:0] cmd, input logic [31:0] ofs,
                                    input logic [31:0] len, input logic [62:0] gas);
    in_t t;
    t                     = random_item();
    t.cmd                 = cmd;
    t.offset              = ofs;
    t.length              = len;
    t.offset_high_nonzero = 1'b0;
    t.length_high_nonzero = 1'b0;
    t.gas_in              = gas;
    return t;
  endfunction

  function automatic logic [62:0] pick_gas();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return 63'($urandom_range(0, 40));
      4:       return '1;
      default: return 63'({$urandom, $urandom});
    endcase
  endfunction

  // mostly inside the current size or just past it, so growth comes in small steps
  function automatic logic [31:0] pick_offset();
    longint unsigned size_bytes;
    longint unsigned ofs;
    size_bytes = grown_words * 32;
    if (size_bytes != 0 && $urandom_range(0, 1) == 1)
      ofs = $urandom_range(0, 32'(size_bytes - 1));
    else
      ofs = ((size_bytes > 32) ? size_bytes - 32 : 0) + $urandom_range(0, 64);
    if (ofs > MAX_OFS) ofs = MAX_OFS;
    return ofs[31:0];
  endfunction

  task automatic sender_pause();
    int gap;
    gap = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      case ($urandom_range(0, 19))
        0:                      quiet_left = $urandom_range(10, 30);
        1, 2, 3, 4, 5, 6, 7, 8: gap = 0;
        17, 18:                 gap = $urandom_range(8, 25);
        default:                gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input in_t t);
    in_valid_i <= 1'b1;
    in_i       <= t;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_results.push_back(compute_access(t));
    items_sent++;
    sender_pause();
  endtask

  task automatic test_directed_basics();
    in_t t;
    send_item(make_item(CMD_SIZE, 0, 0, '1));
    send_item(make_item(CMD_LOAD, 0, 0, '0));
    send_item(make_item(CMD_SIZE, 0, 0, '1));
    send_item(make_item(CMD_STORE, 0, 0, '1));
    send_item(make_item(CMD_LOAD, 0, 0, '0));
    send_item(make_item(CMD_BSTORE, 5, 0, '0));
    send_item(make_item(CMD_LOAD, 1, 0, 63'(growth_charge(33))));
    send_item(make_item(CMD_STORE, 33, 0, 63'(growth_charge(65) - 1)));
    send_item(make_item(CMD_LOAD, 33, 0, '1));
    t = make_item(CMD_EXPAND, '1, 0, 5);
    t.offset_high_nonzero = 1'b1;
    send_item(t);
    t = make_item(CMD_EXPAND, 0, 0, '1);
    t.length_high_nonzero = 1'b1;
    send_item(t);
    t = make_item(CMD_EXPAND, 0, 1, '1);
    t.offset_high_nonzero = 1'b1;
    send_item(t);
    send_item(make_item(CMD_EXPAND, 0, 32'(MAX_OFS + 1), '1));
    send_item(make_item(CMD_LOAD, 32'(MAX_OFS + 1), 0, '1));
    t = make_item(CMD_BSTORE, 3, 0, '1);
    t.offset_high_nonzero = 1'b1;
    send_item(t);
    send_item(make_item(CMD_STORE, '1, 0, '1));
    send_item(make_item(CMD_EXPAND, 200, 56, '1));
    send_item(make_item(CMD_EXPAND, 10, 20, '0));
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
      t = random_item();
      t.cmd = 3'(c);
      send_item(t);
    end
  endtask

  task automatic test_random_traffic();
    in_t t;
    int  sel;
    repeat (RANDOM_ITEMS) begin
      t = random_item();
      t.offset_high_nonzero = 1'b0;
      t.length_high_nonzero = 1'b0;
      t.gas_in = pick_gas();
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        t.cmd    = CMD_LOAD;
        t.offset = pick_offset();
      end else if (sel < 45) begin
        t.cmd    = CMD_STORE;
        t.offset = pick_offset();
      end else if (sel < 57) begin
        t.cmd    = CMD_BSTORE;
        t.offset = pick_offset();
      end else if (sel < 65) begin
        t.cmd = CMD_SIZE;
      end else if (sel < 80) begin
        t.cmd    = CMD_EXPAND;
        t.offset = pick_offset();
        t.length = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
      end else if (sel < 88) begin
        // malformed operands
        case ($urandom_range(0, 3))
          0: begin
            t.cmd                 = 3'($urandom_range(CMD_LOAD, CMD_EXPAND));
            t.offset_high_nonzero = 1'b1;
            t.length              = $urandom_range(1, 100);
          end
          1: begin
            t.cmd    = 3'($urandom_range(CMD_LOAD, CMD_BSTORE));
            t.offset = $urandom_range(32'(MAX_OFS + 1), 32'hFFFF_FFFF);
          end
          2: begin
            t.cmd    = CMD_EXPAND;
            t.offset = pick_offset();
            t.length = $urandom_range(32'(MAX_OFS + 1), 32'hFFFF_FFFF);
          end
          default: begin
            t.cmd                 = CMD_EXPAND;
            t.offset              = pick_offset();
            t.length_high_nonzero = 1'b1;
          end
        endcase
      end else if (sel < 94) begin
        t.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end else begin
        t = random_item();
      end
      send_item(t);
    end
  endtask

  task automatic test_extremes();
    in_t t;
    t = make_item(CMD_STORE, 32'(MAX_OFS), 0, '1);
    t.value_w0 = '1;
    t.value_w1 = '1;
    t.value_w2 = '1;
    t.value_w3 = '1;
    send_item(t);
    send_item(make_item(CMD_LOAD, 32'(MAX_OFS), 0, '1));
    t = make_item(CMD_BSTORE, 32'(MAX_OFS), 0, '1);
    t.value_w0 = '0;
    send_item(t);
    send_item(make_item(CMD_LOAD, 32'(MAX_OFS), 0, '1));
    send_item(make_item(CMD_EXPAND, 32'(MAX_OFS), 32'(MAX_OFS),
                        63'(growth_charge(2 * MAX_OFS) - 1)));
    send_item(make_item(CMD_SIZE, 0, 0, '0));
    send_item(make_item(CMD_EXPAND, 32'(MAX_OFS), 1, '0));
    repeat (40) begin
      t = make_item(3'($urandom_range(CMD_LOAD, CMD_BSTORE)),
                    $urandom_range(0, 32'(MAX_OFS)), 0, pick_gas());
      send_item(t);
    end
  endtask

  // receiver stalls: long free stretches, short blips and occasional long holds
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: free_left = $urandom_range(20, 60);
        9: begin
          stall_left = $urandom_range(10, 30);
          free_left  = $urandom_range(0, 3);
        end
        default: begin
          stall_left = $urandom_range(1, 2);
          free_left  = $urandom_range(0, 3);
        end
      endcase
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no transaction pending at %0t", $time);
      end else begin
        want = expected_results.pop_front();
        if (out_o.status !== want.status || out_o.gas_out !== want.gas_out ||
            out_o.data_w0 !== want.data_w0 || out_o.data_w1 !== want.data_w1 ||
            out_o.data_w2 !== want.data_w2 || out_o.data_w3 !== want.data_w3) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch on result %0d at %0t", results_checked, $time);
            $display("  exp status %0d gas %0d data %h %h %h %h", want.status,
                     want.gas_out, want.data_w3, want.data_w2, want.data_w1, want.data_w0);
            $display("  got status %0d gas %0d data %h %h %h %h", out_o.status,
                     out_o.gas_out, out_o.data_w3, out_o.data_w2, out_o.data_w1,
                     out_o.data_w0);
          end
        end
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_random_traffic();
    test_extremes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    errors += expected_results.size();
    $display("%0d transactions sent, %0d results checked, %0d ran out of gas",
             items_sent, results_checked, oog_count);
    $display("memory grew to %0d bytes with %0d gas charged for expansion",
             grown_words * 32, charged_cost);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
